FILE: design/bcbd_pkg.sv
// Package for the Bray-Curtis balanced dissimilarity block.
// Holds the fixed widths, the sequencer state type and the shared add/sub unit request.
// No dependencies.
package bcbd_pkg;

   localparam int DATA_BITS  = 16;
   localparam int SUM_BITS   = 28;
   localparam int DEN_BITS   = SUM_BITS + 1;
   localparam int ALU_BITS   = SUM_BITS + 2;
   localparam int RATIO_BITS = 17;

   localparam logic [SUM_BITS-1:0] SUM_CAP = '1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD_FIRST,
      ST_ADD_SECOND,
      ST_ADD_SHARED,
      ST_DIFF_B,
      ST_DIFF_C,
      ST_MIN,
      ST_DEN,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type          op;
      logic [ALU_BITS-1:0] a;
      logic [ALU_BITS-1:0] b;
   } alu_req_type;

endpackage

FILE: design/bcbd_alu.sv
// Shared add/subtract unit of the Bray-Curtis balanced dissimilarity block.
// Depends on bcbd_pkg for the request type and widths.
// The top bit of the result is the carry of an add or the borrow of a subtract.
module bcbd_alu import bcbd_pkg::*; (
   input  alu_req_type         req,
   output logic [ALU_BITS:0]   result
);

   always_comb begin
      case (req.op)
         ALU_ADD: result = {1'b0, req.a} + {1'b0, req.b};
         ALU_SUB: result = {1'b0, req.a} - {1'b0, req.b};
         default: result = '0;
      endcase
   end

endmodule

FILE: design/bray_curtis_balanced_dissimilarity.sv
// Channel   Ports                                                    Direction
// req       req_valid, req_stall, req_first_value, req_second_value,  in
//           req_last_pair
// rsp       rsp_valid, rsp_stall, rsp_dissimilarity,                  out
//           rsp_undefined_ratio, rsp_sum_overflow
//
// Each pair goes through the transfer and then three saturating adds on the shared
// add/subtract unit. A marked pair then goes on through two differences, a compare, the
// denominator, FRACTION_BITS + 1 restoring divide steps and the result load; a zero
// denominator skips the divide.
// Reset is synchronous and clears the sequencer, the running sums and the result valid.
// A result waits in its output register; accumulation of the next vector pair goes on
// meanwhile, and only the load of the next result holds until the register is free.
// Top level; depends on bcbd_pkg and bcbd_alu.
module bray_curtis_balanced_dissimilarity import bcbd_pkg::*; #(
   parameter int VALUE_BITS    = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [DATA_BITS-1:0]  req_first_value,
   input  logic [DATA_BITS-1:0]  req_second_value,
   input  logic                  req_last_pair,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [RATIO_BITS-1:0] rsp_dissimilarity,
   output logic                  rsp_undefined_ratio,
   output logic                  rsp_sum_overflow
);

   localparam int QUO_BITS  = FRACTION_BITS + 1;
   localparam int STEP_BITS = $clog2(FRACTION_BITS + 1);
   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(FRACTION_BITS);
   localparam logic [DATA_BITS-1:0] VALUE_MASK = (VALUE_BITS >= DATA_BITS) ? '1 :
      DATA_BITS'((64'd1 << VALUE_BITS) - 64'd1);

   state_type             state_ff, state_in;
   logic [DATA_BITS-1:0]  x_ff, x_in, y_ff, y_in;
   logic                  last_ff, last_in;
   logic [SUM_BITS-1:0]   first_sum_ff, first_sum_in;
   logic [SUM_BITS-1:0]   second_sum_ff, second_sum_in;
   logic [SUM_BITS-1:0]   shared_sum_ff, shared_sum_in;
   logic                  overflow_ff, overflow_in;
   logic [SUM_BITS-1:0]   b_ff, b_in, c_ff, c_in, m_ff, m_in;
   logic [DEN_BITS-1:0]   den_ff, den_in, rem_ff, rem_in;
   logic [QUO_BITS-1:0]   quo_ff, quo_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  undef_ff, undef_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RATIO_BITS-1:0] ratio_ff, ratio_in;
   logic                  rsp_undef_ff, rsp_undef_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   alu_req_type               alu_req;
   logic [ALU_BITS:0]         alu_res;
   logic                      borrow;
   logic                      sum_sat;
   logic [SUM_BITS-1:0]       sat_sum;
   logic [DATA_BITS-1:0]      lo_value;
   logic [ALU_BITS-1:0]       cand;
   logic                      den_zero;
   logic [QUO_BITS+RATIO_BITS-1:0] quo_wide;

   bcbd_alu u_alu (
      .req    (alu_req),
      .result (alu_res)
   );

   assign borrow   = alu_res[ALU_BITS];
   assign sum_sat  = |alu_res[ALU_BITS:SUM_BITS];
   assign sat_sum  = sum_sat ? SUM_CAP : alu_res[SUM_BITS-1:0];
   assign lo_value = (x_ff < y_ff) ? x_ff : y_ff;
   assign cand     = (step_ff == STEP_LAST) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
   assign den_zero = (alu_res[DEN_BITS-1:0] == '0);
   assign quo_wide = {{RATIO_BITS{1'b0}}, quo_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:       if (req_valid) state_in = ST_ADD_FIRST;
         ST_ADD_FIRST:  state_in = ST_ADD_SECOND;
         ST_ADD_SECOND: state_in = ST_ADD_SHARED;
         ST_ADD_SHARED: state_in = last_ff ? ST_DIFF_B : ST_IDLE;
         ST_DIFF_B:     state_in = ST_DIFF_C;
         ST_DIFF_C:     state_in = ST_MIN;
         ST_MIN:        state_in = ST_DEN;
         ST_DEN:        state_in = den_zero ? ST_FINISH : ST_DIVIDE;
         ST_DIVIDE:     if (step_ff == '0) state_in = ST_FINISH;
         ST_FINISH:     if (!rsp_valid_ff) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake and shared unit operands
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      alu_req.op  = ALU_ADD;
      alu_req.a   = '0;
      alu_req.b   = '0;
      case (state_ff)
         ST_ADD_FIRST: begin
            alu_req.a = ALU_BITS'(first_sum_ff);
            alu_req.b = ALU_BITS'(x_ff);
         end
         ST_ADD_SECOND: begin
            alu_req.a = ALU_BITS'(second_sum_ff);
            alu_req.b = ALU_BITS'(y_ff);
         end
         ST_ADD_SHARED: begin
            alu_req.a = ALU_BITS'(shared_sum_ff);
            alu_req.b = ALU_BITS'(lo_value);
         end
         ST_DIFF_B: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = ALU_BITS'(first_sum_ff);
            alu_req.b  = ALU_BITS'(shared_sum_ff);
         end
         ST_DIFF_C: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = ALU_BITS'(second_sum_ff);
            alu_req.b  = ALU_BITS'(shared_sum_ff);
         end
         ST_MIN: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = ALU_BITS'(b_ff);
            alu_req.b  = ALU_BITS'(c_ff);
         end
         ST_DEN: begin
            alu_req.a = ALU_BITS'(shared_sum_ff);
            alu_req.b = ALU_BITS'(m_ff);
         end
         ST_DIVIDE: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = cand;
            alu_req.b  = ALU_BITS'(den_ff);
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      x_in          = x_ff;
      y_in          = y_ff;
      last_in       = last_ff;
      first_sum_in  = first_sum_ff;
      second_sum_in = second_sum_ff;
      shared_sum_in = shared_sum_ff;
      overflow_in   = overflow_ff;
      b_in          = b_ff;
      c_in          = c_ff;
      m_in          = m_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      undef_in      = undef_ff;
      ratio_in      = ratio_ff;
      rsp_undef_in  = rsp_undef_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in    = req_first_value & VALUE_MASK;
               y_in    = req_second_value & VALUE_MASK;
               last_in = req_last_pair;
            end
         end
         ST_ADD_FIRST: begin
            first_sum_in = sat_sum;
            overflow_in  = overflow_ff | sum_sat;
         end
         ST_ADD_SECOND: begin
            second_sum_in = sat_sum;
            overflow_in   = overflow_ff | sum_sat;
         end
         ST_ADD_SHARED: begin
            shared_sum_in = sat_sum;
            overflow_in   = overflow_ff | sum_sat;
         end
         ST_DIFF_B: b_in = borrow ? '0 : alu_res[SUM_BITS-1:0];
         ST_DIFF_C: c_in = borrow ? '0 : alu_res[SUM_BITS-1:0];
         ST_MIN:    m_in = borrow ? b_ff : c_ff;
         ST_DEN: begin
            den_in   = alu_res[DEN_BITS-1:0];
            rem_in   = DEN_BITS'(m_ff);
            undef_in = den_zero;
            quo_in   = '0;
            step_in  = STEP_LAST;
         end
         ST_DIVIDE: begin
            rem_in  = borrow ? cand[DEN_BITS-1:0] : alu_res[DEN_BITS-1:0];
            quo_in  = {quo_ff[QUO_BITS-2:0], !borrow};
            step_in = step_ff - 1'b1;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in  = 1'b1;
               ratio_in      = undef_ff ? '0 : quo_wide[RATIO_BITS-1:0];
               rsp_undef_in  = undef_ff;
               rsp_ovf_in    = overflow_ff;
               first_sum_in  = '0;
               second_sum_in = '0;
               shared_sum_in = '0;
               overflow_in   = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         first_sum_ff  <= '0;
         second_sum_ff <= '0;
         shared_sum_ff <= '0;
         overflow_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_sum_ff  <= first_sum_in;
         second_sum_ff <= second_sum_in;
         shared_sum_ff <= shared_sum_in;
         overflow_ff   <= overflow_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      last_ff      <= last_in;
      b_ff         <= b_in;
      c_ff         <= c_in;
      m_ff         <= m_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      step_ff      <= step_in;
      undef_ff     <= undef_in;
      ratio_ff     <= ratio_in;
      rsp_undef_ff <= rsp_undef_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_dissimilarity   = ratio_ff;
   assign rsp_undefined_ratio = rsp_undef_ff;
   assign rsp_sum_overflow    = rsp_ovf_ff;

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_FINISH))
      else $error("result appeared outside the finish step");

   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_undefined_ratio |-> rsp_dissimilarity == '0)
      else $error("undefined ratio with nonzero dissimilarity");

   a_divide_den: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> den_ff != '0)
      else $error("divide step with zero denominator");

   a_sums_cleared: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && !rsp_valid_ff |=>
         first_sum_ff == '0 && second_sum_ff == '0 && shared_sum_ff == '0 && !overflow_ff)
      else $error("sums not cleared after result load");

endmodule
